### hdl/prqs_pkg.sv
// shared types and constants of the priority ready-queue scheduler
package prqs_pkg;

  localparam int NUM_SLOTS_DEF  = 64;
  localparam int NUM_LEVELS_DEF = 6;

  localparam int REQ_W   = 2;
  localparam int SLOT_W  = 6;
  localparam int LEVEL_W = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD   = 2'd0,
    REQ_BLOCK = 2'd1,
    REQ_YIELD = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_LINK,
    S_UPDATE,
    S_PICK,
    S_SEL,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic take;
    logic check;
    logic link_rd;
    logic update;
    logic pick;
    logic select;
    logic load_rsp;
  } prqs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_valid;
    logic clear_last;
    logic need_link;
    logic need_pick;
    logic rsp_free;
  } prqs_status_t;

endpackage

### hdl/prqs_if.sv
// request and result channels of the scheduler
interface prqs_req_if import prqs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [SLOT_W-1:0]  slot;
  logic [LEVEL_W-1:0] level;
  logic               then_dispatch;

  modport source (output valid, req_type, slot, level, then_dispatch, input ready);
  modport sink   (input valid, req_type, slot, level, then_dispatch, output ready);
endinterface

interface prqs_rsp_if import prqs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] running_slot;
  logic              running_valid;
  logic              switched;
  logic              idle;
  logic              error;

  modport source (output valid, running_slot, running_valid, switched, idle, error,
                  input ready);
  modport sink   (input valid, running_slot, running_valid, switched, idle, error,
                  output ready);
endinterface

### hdl/priority_ready_queue_scheduler_core.sv
// scheduler core: strict priority across levels, fifo order within a level
// a request is taken in idle; the state machine then walks check, then, for a
//   dispatch, link-table read and list update (only while a slot runs), priority
//   pick and select one per cycle; the next request is taken only back in idle
// a waiting result does not stop the next request, but holds it in done until taken
// reset: lists empty, nothing running; then a pass over every slot clears queued marks
module priority_ready_queue_scheduler_core import prqs_pkg::*; #(
  parameter int NumSlots  = NUM_SLOTS_DEF,
  parameter int NumLevels = NUM_LEVELS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  prqs_req_if.sink   req_i,
  prqs_rsp_if.source rsp_o
);

  prqs_cmd_t    cmd;
  prqs_status_t status;

  prqs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  prqs_dpath #(
    .NumSlots  (NumSlots),
    .NumLevels (NumLevels)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .req_i    (req_i),
    .rsp_o    (rsp_o)
  );

endmodule

### hdl/prqs_ctrl.sv
// sequencing state machine of the scheduler
module prqs_ctrl import prqs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  prqs_status_t status_i,
  output prqs_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (status_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (status_i.req_valid) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (status_i.need_link) begin
          state_d = S_LINK;
        end else if (status_i.need_pick) begin
          state_d = S_PICK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_LINK:   state_d = S_UPDATE;
      S_UPDATE: state_d = S_PICK;
      S_PICK:   state_d = S_SEL;
      S_SEL:    state_d = S_DONE;
      S_DONE: begin
        if (status_i.rsp_free) state_d = S_IDLE;
      end
      default:  state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_CLEAR:  cmd_o.clear    = 1'b1;
      S_IDLE:   cmd_o.take     = 1'b1;
      S_CHECK:  cmd_o.check    = 1'b1;
      S_LINK:   cmd_o.link_rd  = 1'b1;
      S_UPDATE: cmd_o.update   = 1'b1;
      S_PICK:   cmd_o.pick     = 1'b1;
      S_SEL:    cmd_o.select   = 1'b1;
      S_DONE:   cmd_o.load_rsp = status_i.rsp_free;
      default:  cmd_o = '0;
    endcase
  end

endmodule

### hdl/prqs_dpath.sv
// level lists, link table, running slot and result register
module prqs_dpath import prqs_pkg::*; #(
  parameter int NumSlots  = NUM_SLOTS_DEF,
  parameter int NumLevels = NUM_LEVELS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  prqs_cmd_t    cmd_i,
  output prqs_status_t status_o,
  prqs_req_if.sink     req_i,
  prqs_rsp_if.source   rsp_o
);

  localparam int SIdxW = $clog2(NumSlots);
  localparam int LIdxW = (NumLevels > 1) ? $clog2(NumLevels) : 1;
  localparam int CntW  = $clog2(NumSlots + 1);

  // per-level list registers
  logic [SIdxW-1:0] head_q [NumLevels];
  logic [SIdxW-1:0] tail_q [NumLevels];
  logic [CntW-1:0]  cnt_q  [NumLevels];

  logic [SIdxW-1:0] run_q;
  logic             run_flag_q;
  logic [SIdxW-1:0] clr_cnt_q;
  logic             rsp_valid_q;

  // latched request and work registers
  logic [REQ_W-1:0]   req_type_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [LEVEL_W-1:0] level_q;
  logic               disp_q;
  logic [SIdxW-1:0]   start_run_q;
  logic               start_flag_q;
  logic [LIdxW-1:0]   lv_q;
  logic               found_q;
  logic               err_q;
  logic               idle_q;
  logic               sw_q;

  // memories
  logic [SIdxW-1:0] next_mem  [NumSlots];
  logic [LIdxW-1:0] lvl_mem   [NumSlots];
  logic             qmark_mem [NumSlots];
  logic [SIdxW-1:0] next_rd_q;
  logic [LIdxW-1:0] lvl_rd_q;
  logic             qmark_rd_q;

  logic             accept;
  logic [SIdxW-1:0] slot_idx;
  logic             is_add, is_block, is_yield;
  logic             add_ok, disp;
  logic             cnt_many, cnt_zero;
  logic             pick_found;
  logic [LIdxW-1:0] pick_lv;

  logic             qm_we, qm_wd;
  logic [SIdxW-1:0] qm_wa;
  logic             nx_we;
  logic [SIdxW-1:0] nx_wd;

  assign accept   = req_i.valid & cmd_i.take;
  assign slot_idx = SIdxW'(slot_q);
  assign is_add   = (req_type_q == REQ_ADD);
  assign is_block = (req_type_q == REQ_BLOCK);
  assign is_yield = (req_type_q == REQ_YIELD);
  assign cnt_many = (cnt_q[lv_q] > CntW'(1));
  assign cnt_zero = (cnt_q[lv_q] == '0);

  // add is rejected for an out-of-range slot or level, or a slot already queued
  assign add_ok = is_add && (32'(slot_q) < 32'(NumSlots)) && (level_q != '0) &&
                  (32'(level_q) <= 32'(NumLevels)) && !qmark_rd_q;
  assign disp   = (add_ok && disp_q) || (is_block && run_flag_q) || is_yield;

  assign status_o.req_valid  = req_i.valid;
  assign status_o.clear_last = (clr_cnt_q == SIdxW'(NumSlots - 1));
  assign status_o.need_link  = disp && run_flag_q;
  assign status_o.need_pick  = disp;
  assign status_o.rsp_free   = !rsp_valid_q || rsp_o.ready;

  assign req_i.ready = cmd_i.take;
  assign rsp_o.valid = rsp_valid_q;

  // lowest-numbered non-empty level
  always_comb begin
    pick_found = 1'b0;
    pick_lv    = '0;
    for (int i = NumLevels - 1; i >= 0; i--) begin
      if (cnt_q[i] != '0) begin
        pick_found = 1'b1;
        pick_lv    = LIdxW'(i);
      end
    end
  end

  always_comb begin
    qm_we = 1'b0;
    qm_wa = clr_cnt_q;
    qm_wd = 1'b0;
    if (cmd_i.clear) begin
      qm_we = 1'b1;
    end else if (cmd_i.check && add_ok) begin
      qm_we = 1'b1;
      qm_wa = slot_idx;
      qm_wd = 1'b1;
    end else if (cmd_i.update && is_block && !cnt_zero) begin
      qm_we = 1'b1;
      qm_wa = head_q[lv_q];
    end
  end

  always_comb begin
    nx_we = 1'b0;
    nx_wd = slot_idx;
    if (cmd_i.check && add_ok && !cnt_zero) begin
      nx_we = 1'b1;
    end else if (cmd_i.update && !is_block && cnt_many) begin
      // rotate: old head goes behind the tail
      nx_we = 1'b1;
      nx_wd = head_q[lv_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (nx_we) next_mem[tail_q[lv_q]] <= nx_wd;
    if (cmd_i.link_rd) next_rd_q <= next_mem[head_q[lv_q]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check && add_ok) lvl_mem[slot_idx] <= lv_q;
    if (accept) lvl_rd_q <= lvl_mem[run_q];
  end

  always_ff @(posedge clk_i) begin
    if (qm_we) qmark_mem[qm_wa] <= qm_wd;
    if (accept) qmark_rd_q <= qmark_mem[SIdxW'(req_i.slot)];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLevels; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      run_q       <= '0;
      run_flag_q  <= 1'b0;
      clr_cnt_q   <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_cnt_q <= clr_cnt_q + SIdxW'(1);
      if (cmd_i.check && add_ok) begin
        if (cnt_zero) head_q[lv_q] <= slot_idx;
        tail_q[lv_q] <= slot_idx;
        cnt_q[lv_q]  <= cnt_q[lv_q] + CntW'(1);
      end
      if (cmd_i.update) begin
        if (is_block) begin
          if (cnt_many) head_q[lv_q] <= next_rd_q;
          if (!cnt_zero) cnt_q[lv_q] <= cnt_q[lv_q] - CntW'(1);
          run_flag_q <= 1'b0;
        end else if (cnt_many) begin
          head_q[lv_q] <= next_rd_q;
          tail_q[lv_q] <= head_q[lv_q];
        end
      end
      if (cmd_i.select && found_q) begin
        run_q      <= head_q[lv_q];
        run_flag_q <= 1'b1;
      end
      if (cmd_i.load_rsp) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // payload and work registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q   <= req_i.req_type;
      slot_q       <= req_i.slot;
      level_q      <= req_i.level;
      disp_q       <= req_i.then_dispatch;
      start_run_q  <= run_q;
      start_flag_q <= run_flag_q;
      lv_q         <= LIdxW'(req_i.level - LEVEL_W'(1));
      err_q        <= 1'b0;
      idle_q       <= 1'b0;
      sw_q         <= 1'b0;
    end
    if (cmd_i.check) begin
      err_q <= (is_add && !add_ok) || (is_block && !run_flag_q);
      // block and rotation work on the running slot's level, after any append
      lv_q <= lvl_rd_q;
    end
    if (cmd_i.pick) begin
      found_q <= pick_found;
      lv_q    <= pick_lv;
    end
    if (cmd_i.select) begin
      if (found_q) begin
        sw_q <= !(start_flag_q && (start_run_q == head_q[lv_q]));
      end else begin
        idle_q <= 1'b1;
      end
    end
    if (cmd_i.load_rsp) begin
      rsp_o.running_slot  <= SLOT_W'(run_q);
      rsp_o.running_valid <= run_flag_q;
      rsp_o.switched      <= sw_q;
      rsp_o.idle          <= idle_q;
      rsp_o.error         <= err_q;
    end
  end

endmodule
